>>> rtl/rcv_pkg.sv
`timescale 1ns / 1ps

package rcv_pkg;

  // SDES walk phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_SOURCE = 3'd1;
  localparam logic [2:0] PH_TYPE   = 3'd2;
  localparam logic [2:0] PH_LENGTH = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;
  localparam logic [2:0] PH_FILL   = 3'd5;

  // RTCP block types
  localparam logic [7:0] TYPE_SR   = 8'd200;
  localparam logic [7:0] TYPE_RR   = 8'd201;
  localparam logic [7:0] TYPE_SDES = 8'd202;
  localparam logic [7:0] TYPE_BYE  = 8'd203;
  localparam logic [7:0] TYPE_APP  = 8'd204;
  localparam logic [7:0] TYPE_RTPFB = 8'd205;
  localparam logic [7:0] TYPE_PSFB = 8'd206;
  localparam logic [7:0] TYPE_XR   = 8'd207;

  localparam logic [7:0] SSRC_BYTES = 8'd4;

  typedef struct packed {
    logic [2:0]  phase;
    logic [4:0]  chunks_left;
    logic [7:0]  item_left;
    logic [15:0] finish;
    logic        done;
  } sdes_state_t;

endpackage

>>> rtl/rtcp_compound_validator.sv
`timescale 1ns / 1ps

// Compound RTCP packet checker. Bytes of one packet enter on the s_ side, one
// byte per cycle while s_tready is high, no gaps required, s_tlast on the final
// byte. Each byte is parsed in the cycle it is accepted, so a new byte is taken
// every cycle unless s_tready is low; the verdict for a packet appears on the
// m_ side in the cycle after its last byte and is held in an output register
// until it is taken. s_tready drops only while a verdict is held and m_tready
// is low. Checks: version 2 on every block, block lengths landing on the packet
// end, padding only on the final block with a sane pad count, minimum sizes for
// types 200-207, a full walk of SDES chunks, and a packet size limit of
// MAX_PACKET_BYTES. A 0 on m_tdata[0] means malformed.

module rtcp_compound_validator #(
  parameter int MAX_PACKET_BYTES = 65535
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // last_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] valid_res, [7:1] zero
);
  import rcv_pkg::*;

  localparam logic [16:0] MaxBytes = 17'(MAX_PACKET_BYTES);

  logic [15:0] byte_position, byte_position_next;
  logic [15:0] block_start, block_start_next;
  logic [18:0] block_end, block_end_next;
  logic [7:0]  block_first_byte, block_first_byte_next;
  logic [7:0]  block_type, block_type_next;
  logic [7:0]  length_high, length_high_next;
  sdes_state_t sdes, sdes_next, sdes_walked;
  logic        failed;
  logic        result;

  logic        accept;
  logic        over;
  logic        fail_a, fail_b;
  logic        walk_fail;
  logic [15:0] rel;
  logic [15:0] pos_inc;
  logic [16:0] pos_inc_w;
  logic [16:0] words_inc;
  logic [18:0] body;
  logic [18:0] pay_end;
  logic        ok;

  function automatic logic type_ok(input logic [18:0] pe, input logic [15:0] start,
                                   input logic [7:0] fb, input logic [7:0] btype,
                                   input sdes_state_t sd);
    logic [18:0] avail;
    logic [9:0]  cnt;
    avail = pe - {3'b000, start};
    cnt   = {5'd0, fb[4:0]};
    case (btype)
      TYPE_SR:   type_ok = avail >= 19'(10'd28 + cnt * 10'd24);
      TYPE_RR:   type_ok = avail >= 19'(10'd8 + cnt * 10'd24);
      TYPE_SDES: type_ok = sd.done && ({3'b000, sd.finish} == pe);
      TYPE_BYE:  type_ok = avail >= 19'(10'd4 + cnt * 10'd4);
      TYPE_APP, TYPE_RTPFB, TYPE_PSFB: type_ok = avail >= 19'd12;
      TYPE_XR:   type_ok = avail >= 19'd8;
      default:   type_ok = 1'b1;
    endcase
  endfunction

  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign m_tdata   = {7'd0, result};

  assign pos_inc_w = {1'b0, byte_position} + 17'd1;
  assign pos_inc   = pos_inc_w[15:0];
  assign over      = (byte_position == 16'hffff) || (pos_inc_w > MaxBytes);
  assign rel       = byte_position - block_start;
  assign words_inc = {1'b0, length_high, s_tdata} + 17'd1;

  rcv_sdes_walk u_walk (
    .cur       (sdes),
    .data_byte (s_tdata),
    .aligned   (rel[1:0] == 2'd3),
    .next_pos  (pos_inc),
    .nxt       (sdes_walked),
    .walk_fail (walk_fail)
  );

  always_comb begin
    byte_position_next    = over ? byte_position : pos_inc;
    block_start_next      = block_start;
    block_end_next        = block_end;
    block_first_byte_next = block_first_byte;
    block_type_next       = block_type;
    length_high_next      = length_high;
    sdes_next             = sdes;
    fail_a                = failed || over;

    if (!fail_a) begin
      case (rel)
        16'd0: begin
          block_first_byte_next = s_tdata;
          if (s_tdata[7:6] != 2'd2) fail_a = 1'b1;
        end
        16'd1: block_type_next  = s_tdata;
        16'd2: length_high_next = s_tdata;
        16'd3: begin
          block_end_next = {3'b000, block_start} + {words_inc, 2'b00};
          sdes_next.done  = 1'b0;
          sdes_next.phase = PH_IDLE;
          if (block_type == TYPE_SDES) begin
            sdes_next.chunks_left = block_first_byte[4:0];
            if (block_first_byte[4:0] == 5'd0) begin
              sdes_next.done   = 1'b1;
              sdes_next.finish = block_start + 16'd4;
            end else begin
              sdes_next.phase     = PH_SOURCE;
              sdes_next.item_left = SSRC_BYTES;
            end
          end
        end
        default: begin
          sdes_next = sdes_walked;
          if (walk_fail) fail_a = 1'b1;
        end
      endcase
    end

    // block boundary inside the packet
    fail_b = fail_a;
    if (!fail_a && !s_tlast && rel >= 16'd3 && {2'b00, pos_inc_w} == block_end_next) begin
      if (block_first_byte_next[5]) fail_b = 1'b1;
      else if (!type_ok(block_end_next, block_start, block_first_byte_next, block_type_next,
                        sdes_next)) fail_b = 1'b1;
      block_start_next = block_end_next[15:0];
      sdes_next.phase  = PH_IDLE;
      sdes_next.done   = 1'b0;
    end

    // verdict at packet end
    body    = block_end_next - {3'b000, block_start} - 19'd4;
    pay_end = block_end_next;
    ok      = !fail_b;
    if (ok) begin
      if (rel < 16'd3 || block_end_next != {2'b00, pos_inc_w}) begin
        ok = 1'b0;
      end else begin
        if (block_first_byte_next[5]) begin
          if (s_tdata == 8'd0 || {11'd0, s_tdata} > body) ok = 1'b0;
          else pay_end = block_end_next - {11'd0, s_tdata};
        end
        if (ok && !type_ok(pay_end, block_start, block_first_byte_next, block_type_next,
                           sdes_next)) ok = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      block_start      <= '0;
      block_end        <= '0;
      block_first_byte <= '0;
      block_type       <= '0;
      length_high      <= '0;
      sdes             <= '0;
      failed           <= 1'b0;
      m_tvalid         <= 1'b0;
    end else begin
      if (accept) begin
        if (s_tlast) begin
          byte_position    <= '0;
          block_start      <= '0;
          block_end        <= '0;
          block_first_byte <= '0;
          block_type       <= '0;
          length_high      <= '0;
          sdes             <= '0;
          failed           <= 1'b0;
        end else begin
          byte_position    <= byte_position_next;
          block_start      <= block_start_next;
          block_end        <= block_end_next;
          block_first_byte <= block_first_byte_next;
          block_type       <= block_type_next;
          length_high      <= length_high_next;
          sdes             <= sdes_next;
          failed           <= fail_b;
        end
      end
      if (accept && s_tlast) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_tlast) result <= ok;
  end

  a_pos_cleared: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> byte_position == 16'd0 && !failed)
    else $error("parser state not cleared after packet end");

  a_pos_limit: assert property (@(posedge clk) disable iff (rst)
    {1'b0, byte_position} <= MaxBytes)
    else $error("byte position past packet limit");

  a_start_order: assert property (@(posedge clk) disable iff (rst)
    !failed |-> block_start <= byte_position)
    else $error("block start ahead of byte position");

  a_sdes_done_idle: assert property (@(posedge clk) disable iff (rst)
    sdes.done |-> sdes.phase == PH_IDLE)
    else $error("SDES walk finished but still active");

  a_verdict_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(accept && s_tlast))
    else $error("verdict without a packet end");

endmodule

>>> rtl/rcv_sdes_walk.sv
`timescale 1ns / 1ps

module rcv_sdes_walk (
  input  rcv_pkg::sdes_state_t cur,
  input  logic [7:0]           data_byte,
  input  logic                 aligned,    // byte after this one is on a 4-byte boundary
  input  logic [15:0]          next_pos,
  output rcv_pkg::sdes_state_t nxt,
  output logic                 walk_fail
);
  import rcv_pkg::*;

  logic [4:0]  chunks_dec;
  logic [7:0]  item_dec;
  sdes_state_t chunk_end;

  assign chunks_dec = cur.chunks_left - 5'd1;
  assign item_dec   = cur.item_left - 8'd1;

  // state after a chunk closes: either the walk is finished or a new source starts
  always_comb begin
    chunk_end = cur;
    chunk_end.chunks_left = chunks_dec;
    if (chunks_dec == 5'd0) begin
      chunk_end.done   = 1'b1;
      chunk_end.finish = next_pos;
      chunk_end.phase  = PH_IDLE;
    end else begin
      chunk_end.phase     = PH_SOURCE;
      chunk_end.item_left = SSRC_BYTES;
    end
  end

  always_comb begin
    nxt = cur;
    walk_fail = 1'b0;
    case (cur.phase)
      PH_SOURCE, PH_DATA: begin
        nxt.item_left = item_dec;
        if (item_dec == 8'd0) nxt.phase = PH_TYPE;
      end
      PH_TYPE: begin
        if (data_byte == 8'd0) begin
          if (aligned) nxt = chunk_end;
          else nxt.phase = PH_FILL;
        end else begin
          nxt.phase = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        nxt.item_left = data_byte;
        nxt.phase = (data_byte == 8'd0) ? PH_TYPE : PH_DATA;
      end
      PH_FILL: begin
        if (data_byte != 8'd0) walk_fail = 1'b1;
        else if (aligned) nxt = chunk_end;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> verif/tb_rtcp_compound_validator.sv
`timescale 1ns / 1ps

module tb_rtcp_compound_validator;
  import rcv_pkg::*;

  localparam int MAX_BYTES      = 65535;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 1000;
  localparam int DIR_MAX        = 28;
  localparam int N_DIR          = 25;
  localparam int RAND_BYTES     = 260;
  localparam int RAND_PACKETS   = 6;

  logic       clk;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;
  logic       s_tlast  = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;

  rtcp_compound_validator #(.MAX_PACKET_BYTES(MAX_BYTES)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Directed packets; verdict -1 means the parser model decides.
  typedef struct {
    int                     len;
    logic [8*DIR_MAX-1:0]   bytes;
    int                     verdict;
  } dir_row_t;

  dir_row_t dir_table [N_DIR] = '{
    '{8,  64'h80c90001_a1b2c3d4, 1},                          // minimal RR
    '{8,  64'h40c90001_a1b2c3d4, 0},                          // version 1
    '{8,  64'hffc90001_00000000, 0},                          // version 3
    '{2,  16'h80c9, 0},                                       // header cut short
    '{1,  8'h80, 0},                                          // one byte
    '{8,  64'h80c90002_a1b2c3d4, 0},                          // block overruns packet
    '{12, 96'ha0c90002_a1b2c3d4_00000004, 1},                 // padded RR
    '{12, 96'ha0c90002_a1b2c3d4_00000000, 0},                 // zero pad count
    '{12, 96'ha0000002_a1b2c3d4_00000008, 1},                 // pad fills the body
    '{12, 96'ha0000002_a1b2c3d4_000000ff, 0},                 // pad beyond body
    '{16, 128'ha0c90001_a1b2c3d4_80c90001_a1b2c3d4, 0},       // padding not on final block
    '{16, 128'h80c90001_a1b2c3d4_80ca0000_80000000, 1},       // RR + empty SDES + unknown
    '{28, 224'h80c80006_ffffffff_ffffffff_ffffffff_ffffffff_ffffffff_ffffffff, 1},
    '{24, 192'h80c80005_ffffffff_ffffffff_ffffffff_ffffffff_ffffffff, 0},
    '{12, 96'h81ca0002_a1b2c3d4_01014100, 1},                 // SDES one item
    '{12, 96'h81ca0002_a1b2c3d4_01000005, 0},                 // nonzero fill
    '{16, 128'h81ca0003_a1b2c3d4_01014100_00000000, 0},       // walk ends before block
    '{20, 160'h82ca0004_a1b2c3d4_00000000_1a2b3c4d_00000000, -1},
    '{12, 96'h81ca0002_a1b2c3d4_010a4142, -1},                // item runs past block
    '{8,  64'h81cb0001_a1b2c3d4, 1},                          // BYE
    '{8,  64'h80cc0001_a1b2c3d4, 0},                          // APP too short
    '{8,  64'h80cf0001_00000000, 1},                          // XR
    '{4,  32'h80ff0000, 1},                                   // unknown type, header only
    '{12, 96'h80ce0002_00000000_00000000, 1},                 // PSFB
    '{8,  64'h80cd0001_a1b2c3d4, 0}                           // RTPFB too short
  };

  // parser model state
  logic [15:0] pos;
  logic [15:0] blk_start;
  logic [18:0] blk_end;
  logic [7:0]  blk_first;
  logic [7:0]  blk_type;
  logic [7:0]  len_hi;
  logic [2:0]  sd_phase;
  logic [4:0]  sd_chunks;
  logic [7:0]  sd_item;
  logic [15:0] sd_finish;
  bit          sd_done;
  bit          pkt_failed;

  logic [7:0] pkt_bytes [$];
  int         listed_verdicts [$];
  bit         pending_verdicts [$];

  int  errors        = 0;
  int  verdicts_seen = 0;
  int  good_seen     = 0;
  int  bytes_sent    = 0;
  int  packets_sent  = 0;
  int  quiet_cycles  = 0;
  bit  tx_calm       = 1'b0;
  bit  rx_calm       = 1'b0;
  bit  long_hold_req = 1'b0;

  function automatic void clear_parser();
    pos = '0; blk_start = '0; blk_end = '0;
    blk_first = '0; blk_type = '0; len_hi = '0;
    sd_phase = PH_IDLE; sd_chunks = '0; sd_item = '0; sd_finish = '0;
    sd_done = 1'b0; pkt_failed = 1'b0;
  endfunction

  function automatic bit type_fits(input int unsigned pe);
    int unsigned avail;
    int unsigned c;
    avail = pe - blk_start;
    c = blk_first[4:0];
    case (blk_type)
      TYPE_SR:                         return avail >= 28 + c * 24;
      TYPE_RR:                         return avail >= 8 + c * 24;
      TYPE_SDES:                       return sd_done && sd_finish == pe;
      TYPE_BYE:                        return avail >= 4 + c * 4;
      TYPE_APP, TYPE_RTPFB, TYPE_PSFB: return avail >= 12;
      TYPE_XR:                         return avail >= 8;
      default:                         return 1'b1;
    endcase
  endfunction

  function automatic void close_chunk(input int unsigned next);
    sd_chunks = sd_chunks - 5'd1;
    if (sd_chunks == 0) begin
      sd_done = 1'b1;
      sd_finish = 16'(next);
      sd_phase = PH_IDLE;
    end else begin
      sd_phase = PH_SOURCE;
      sd_item = SSRC_BYTES;
    end
  endfunction

  function automatic void walk_sdes(input int unsigned p, input logic [7:0] b);
    int unsigned next;
    bit          aligned;
    next = p + 1;
    aligned = ((next - blk_start) & 3) == 0;
    case (sd_phase)
      PH_SOURCE, PH_DATA: begin
        sd_item = sd_item - 8'd1;
        if (sd_item == 0) sd_phase = PH_TYPE;
      end
      PH_TYPE: begin
        if (b == 0) begin
          if (aligned) close_chunk(next);
          else sd_phase = PH_FILL;
        end else begin
          sd_phase = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        sd_item = b;
        sd_phase = (b == 0) ? PH_TYPE : PH_DATA;
      end
      PH_FILL: begin
        if (b != 0) pkt_failed = 1'b1;
        else if (aligned) close_chunk(next);
      end
      default: ;
    endcase
  endfunction

  // Advance the parser by one byte; returns 1 when the packet ends, with its verdict.
  function automatic bit rtcp_verdict_step(input logic [7:0] b, input logic last,
                                           output bit good);
    int unsigned p, rel, words, pe, body;
    good = 1'b0;
    p = pos;
    rel = p - blk_start;
    if (p >= 32'hffff || p + 1 > MAX_BYTES) pkt_failed = 1'b1;
    else pos = 16'(p + 1);

    if (!pkt_failed) begin
      if (rel == 0) begin
        blk_first = b;
        if (b[7:6] != 2'd2) pkt_failed = 1'b1;
      end else if (rel == 1) begin
        blk_type = b;
      end else if (rel == 2) begin
        len_hi = b;
      end else if (rel == 3) begin
        words = {len_hi, b};
        blk_end = 19'(blk_start + (words + 1) * 4);
        sd_done = 1'b0;
        sd_phase = PH_IDLE;
        if (blk_type == TYPE_SDES) begin
          sd_chunks = blk_first[4:0];
          if (sd_chunks == 0) begin
            sd_done = 1'b1;
            sd_finish = blk_start + 16'd4;
          end else begin
            sd_phase = PH_SOURCE;
            sd_item = SSRC_BYTES;
          end
        end
      end else begin
        walk_sdes(p, b);
      end
    end

    // block boundary inside the packet
    if (!pkt_failed && !last && rel >= 3 && p + 1 == blk_end) begin
      if (blk_first[5]) pkt_failed = 1'b1;
      else if (!type_fits(blk_end)) pkt_failed = 1'b1;
      blk_start = blk_end[15:0];
      sd_phase = PH_IDLE;
      sd_done = 1'b0;
    end

    if (!last) return 1'b0;

    if (!pkt_failed) begin
      if (rel < 3 || blk_end != p + 1) begin
        pkt_failed = 1'b1;
      end else begin
        pe = blk_end;
        if (blk_first[5]) begin
          body = blk_end - blk_start - 4;
          if (b == 0 || b > body) pkt_failed = 1'b1;
          else pe = blk_end - b;
        end
        if (!pkt_failed && !type_fits(pe)) pkt_failed = 1'b1;
      end
    end
    good = !pkt_failed;
    clear_parser();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    $display("ERROR %0t ns: %s", $time, what);
  endtask

  // One block, mostly well formed, appended to pkt_bytes.
  function automatic void add_block(input bit pad_it);
    logic [7:0]  body [$];
    logic [7:0]  btype;
    int unsigned kind, c, n, ilen, npad, words;
    kind = $urandom_range(0, 9);
    btype = (kind < 8) ? 8'(200 + kind) : 8'($urandom);
    c = ($urandom_range(0, 31) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 2);
    case (btype)
      TYPE_SR:                         n = 24 + 24 * c;
      TYPE_RR:                         n = 4 + 24 * c;
      TYPE_BYE:                        n = 4 * c;
      TYPE_APP, TYPE_RTPFB, TYPE_PSFB: n = 8;
      TYPE_XR:                         n = 4;
      default:                         n = 0;
    endcase
    if (btype == TYPE_SDES) begin
      repeat (c) begin
        repeat (4) body.push_back(8'($urandom));
        repeat ($urandom_range(0, 2)) begin
          ilen = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255)
                                              : $urandom_range(0, 6);
          body.push_back(8'($urandom_range(1, 255)));
          body.push_back(8'(ilen));
          repeat (ilen) body.push_back(8'($urandom));
        end
        body.push_back(8'h00);
        while (body.size() % 4 != 0) body.push_back(8'h00);
      end
    end else begin
      n += 4 * $urandom_range(0, 2);
      // now and then drop one word, which can leave the body short of the type minimum
      if (n >= 4 && $urandom_range(0, 7) == 0) n -= 4;
      repeat (n) body.push_back(8'($urandom));
    end
    if (pad_it) begin
      npad = 4 * $urandom_range(1, 2);
      repeat (npad - 1) body.push_back(8'h00);
      body.push_back(8'(npad));
    end
    words = body.size() / 4;
    pkt_bytes.push_back({2'b10, pad_it, 5'(c)});
    pkt_bytes.push_back(btype);
    pkt_bytes.push_back(8'(words >> 8));
    pkt_bytes.push_back(8'(words));
    foreach (body[i]) pkt_bytes.push_back(body[i]);
  endfunction

  function automatic void make_packet();
    int nblk, k, idx, n;
    pkt_bytes = {};
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 12)) pkt_bytes.push_back(8'($urandom));
      return;
    end
    nblk = $urandom_range(1, 3);
    for (k = 0; k < nblk; k++) add_block(k == nblk - 1 && $urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) < 3) begin
      idx = $urandom_range(0, pkt_bytes.size() - 1);
      case ($urandom_range(0, 4))
        0: pkt_bytes[idx] = pkt_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
        1: begin
          n = $urandom_range(1, 6);
          while (n > 0 && pkt_bytes.size() > 1) begin
            void'(pkt_bytes.pop_back());
            n--;
          end
        end
        2: repeat ($urandom_range(1, 4)) pkt_bytes.push_back(8'($urandom));
        3: pkt_bytes[0] = pkt_bytes[0] ^ 8'h20;
        default: pkt_bytes[pkt_bytes.size() - 1] = 8'($urandom);
      endcase
    end
  endfunction

  task automatic send_packet(input int listed, input bit gapless);
    int gap;
    listed_verdicts.push_back(listed);
    foreach (pkt_bytes[i]) begin
      if ($urandom_range(0, 7) == 0) tx_calm = !tx_calm;
      gap = (gapless || tx_calm) ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= pkt_bytes[i];
      s_tlast  <= (i == pkt_bytes.size() - 1);
      @(posedge clk);
      while (!s_tready) @(posedge clk);
    end
    bytes_sent += pkt_bytes.size();
    packets_sent++;
  endtask

  // input/output monitor and scoreboard
  always @(posedge clk) begin
    bit good;
    bit want;
    int listed;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        if (rtcp_verdict_step(s_tdata, s_tlast, good)) begin
          listed = listed_verdicts.pop_front();
          pending_verdicts.push_back(listed < 0 ? good : listed[0]);
        end
      end
      if (m_tvalid && m_tready) begin
        verdicts_seen++;
        if (m_tdata[0]) good_seen++;
        if (pending_verdicts.size() == 0) begin
          report_mismatch($sformatf("verdict %0d with no packet pending", m_tdata[0]));
        end else begin
          want = pending_verdicts.pop_front();
          if (m_tdata[0] !== want)
            report_mismatch($sformatf("packet %0d: valid_res %b, expected %b",
                                      verdicts_seen, m_tdata[0], want));
          if (m_tdata[7:1] !== 7'd0)
            report_mismatch($sformatf("packet %0d: m_tdata pad bits %b",
                                      verdicts_seen, m_tdata[7:1]));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d verdicts outstanding",
                 WATCHDOG_LIMIT, pending_verdicts.size());
        $display("tb_rtcp_compound_validator: FAIL");
        $finish;
      end
    end
  end

  // verdict receiver
  initial begin
    int hold;
    bit long_one;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      long_one = long_hold_req;
      if (long_one) long_hold_req = 1'b0;
      if ($urandom_range(0, 7) == 0) rx_calm = !rx_calm;
      hold = long_one ? LONG_HOLD : (rx_calm ? 0 : $urandom_range(0, 16));
      if (hold != 0) begin
        m_tready <= 1'b0;
        // sometimes start the stall once a verdict is already waiting
        if (!long_one && $urandom_range(0, 1)) begin
          @(posedge clk);
          while (!m_tvalid) @(posedge clk);
        end
        repeat (hold) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  initial begin
    int k, i, rand_bytes, rand_packets;
    clear_parser();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (k = 0; k < N_DIR; k++) begin
      pkt_bytes = {};
      for (i = 0; i < dir_table[k].len; i++)
        pkt_bytes.push_back(dir_table[k].bytes[8 * (dir_table[k].len - 1 - i) +: 8]);
      send_packet(dir_table[k].verdict, 1'b0);
    end

    long_hold_req = 1'b1;
    rand_bytes = 0;
    rand_packets = 0;
    while (rand_bytes < RAND_BYTES || rand_packets < RAND_PACKETS) begin
      make_packet();
      rand_bytes += pkt_bytes.size();
      rand_packets++;
      send_packet(-1, 1'b0);
    end
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Sent %0d packets (%0d bytes): %0d directed, %0d random.",
             packets_sent, bytes_sent, N_DIR, rand_packets);
    $display("Checked %0d verdicts: %0d well formed, %0d malformed; %0d mismatches.",
             verdicts_seen, good_seen, verdicts_seen - good_seen, errors);
    if (errors == 0) $display("tb_rtcp_compound_validator: PASS");
    else $display("tb_rtcp_compound_validator: FAIL");
    $finish;
  end

endmodule
